FILE: design/nsr_pkg.sv
// shared constants, types and the sequencer microcode for the newton square root
// no dependencies; compiled first
package nsr_pkg;

   localparam int FRACTION_BITS  = 16;
   localparam int RADICAND_BITS  = 31;
   localparam int RADICAND_WIDTH = 31;
   localparam int ROOT_WIDTH     = 32;
   localparam int TOL_WIDTH      = 16;
   localparam int EST_BITS       = RADICAND_BITS + FRACTION_BITS;
   localparam int QUO_WIDTH      = 64;
   localparam int DIV_STEPS      = RADICAND_BITS + 2 * FRACTION_BITS;
   localparam int COUNT_BITS     = $clog2(DIV_STEPS);

   localparam logic [TOL_WIDTH-1:0]  TOL_RESET = TOL_WIDTH'(66);
   localparam logic [QUO_WIDTH-1:0]  ROOT_MAX  = QUO_WIDTH'({ROOT_WIDTH{1'b1}});

   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_DIV_INIT,
      STEP_DIV_RUN,
      STEP_TEST,
      STEP_UPDATE,
      STEP_EMIT
   } nsr_step_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_REQ_VALID,
      COND_DIV_DONE,
      COND_STOP,
      COND_OUT_FREE
   } nsr_cond_type;

   // accept and emit are qualified by the branch condition
   typedef struct packed {
      nsr_cond_type cond;
      nsr_step_type target_true;
      nsr_step_type target_false;
      logic         accept;
      logic         div_init;
      logic         div_step;
      logic         update;
      logic         emit;
   } nsr_uword_type;

   typedef struct packed {
      logic init;
      logic step;
   } nsr_div_ctrl_type;

   function automatic nsr_uword_type microcode(input nsr_step_type step);
      nsr_uword_type w;
      w = '{COND_ALWAYS, STEP_IDLE, STEP_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
      case (step)
         STEP_IDLE: begin
            w.cond = COND_REQ_VALID;
            w.target_true = STEP_DIV_INIT;
            w.target_false = STEP_IDLE;
            w.accept = 1'b1;
         end
         STEP_DIV_INIT: begin
            w.cond = COND_ALWAYS;
            w.target_true = STEP_DIV_RUN;
            w.div_init = 1'b1;
         end
         STEP_DIV_RUN: begin
            w.cond = COND_DIV_DONE;
            w.target_true = STEP_TEST;
            w.target_false = STEP_DIV_RUN;
            w.div_step = 1'b1;
         end
         STEP_TEST: begin
            w.cond = COND_STOP;
            w.target_true = STEP_EMIT;
            w.target_false = STEP_UPDATE;
         end
         STEP_UPDATE: begin
            w.cond = COND_ALWAYS;
            w.target_true = STEP_DIV_INIT;
            w.update = 1'b1;
         end
         STEP_EMIT: begin
            w.cond = COND_OUT_FREE;
            w.target_true = STEP_IDLE;
            w.target_false = STEP_EMIT;
            w.emit = 1'b1;
         end
         default: begin
            w.cond = COND_ALWAYS;
            w.target_true = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

FILE: design/nsr_if.sv
// request and response channel interfaces with valid/ready handshake
// depends on nsr_pkg
interface nsr_req_if;
   import nsr_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [RADICAND_WIDTH-1:0] radicand;
   modport source (output valid, output radicand, input ready);
   modport sink (input valid, input radicand, output ready);
endinterface

interface nsr_rsp_if;
   import nsr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [ROOT_WIDTH-1:0] root;
   modport source (output valid, output root, input ready);
   modport sink (input valid, input root, output ready);
endinterface

FILE: design/nsr_divider.sv
// bit-serial restoring divider: floor(x * 2^(2F) / den), one quotient bit per cycle
// while div_ctrl.step is high; depends on nsr_pkg
module nsr_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  nsr_pkg::nsr_div_ctrl_type           div_ctrl,
   input  logic [nsr_pkg::RADICAND_BITS-1:0]   x,
   input  logic [nsr_pkg::EST_BITS-1:0]        den,
   output logic                                done,
   output logic [nsr_pkg::QUO_WIDTH-1:0]       quotient
);
   import nsr_pkg::*;

   logic [RADICAND_BITS-1:0] dividend_ff, dividend_in;
   logic [EST_BITS-1:0]      rem_ff, rem_in;
   logic [QUO_WIDTH-1:0]     quo_ff, quo_in;
   logic                     over_ff, over_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic [EST_BITS:0]        rem_shift;
   logic                     fits;

   assign rem_shift = {rem_ff, dividend_ff[RADICAND_BITS-1]};
   assign fits      = rem_shift >= {1'b0, den};
   assign done      = count_ff == COUNT_BITS'(DIV_STEPS - 1);

   always_comb begin
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      over_in     = over_ff;
      count_in    = count_ff;
      if (div_ctrl.init) begin
         dividend_in = x;
         rem_in      = '0;
         quo_in      = '0;
         over_in     = 1'b0;
         count_in    = '0;
      end else if (div_ctrl.step) begin
         dividend_in = {dividend_ff[RADICAND_BITS-2:0], 1'b0};
         over_in     = over_ff | quo_ff[QUO_WIDTH-1];
         count_in    = count_ff + COUNT_BITS'(1);
         if (fits) begin
            rem_in = EST_BITS'(rem_shift - {1'b0, den});
            quo_in = {quo_ff[QUO_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[EST_BITS-1:0];
            quo_in = {quo_ff[QUO_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      over_ff     <= over_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // zero divisor or overflow saturates
   assign quotient = (den == '0 || over_ff) ? '1 : quo_ff;

endmodule

FILE: design/newton_square_root.sv
// newton square root: one request enters, passes of k = (x/k + k)/2 run until
// k - x/k falls to or below the tolerance; each pass is one init step, the division
// steps and one test step, plus one update step between passes
// throughput: one request at a time; the next is taken in the idle step after emit,
// once req.valid is high
// reset: sequencer idle, response empty, tolerance back to 66; no clearing pass
module newton_square_root (
   input  logic                               clock,
   input  logic                               reset,
   nsr_req_if.sink                            req,
   nsr_rsp_if.source                          rsp,
   input  logic                               csr_write_enable,
   input  logic [nsr_pkg::TOL_WIDTH-1:0]      csr_write_data
);
   import nsr_pkg::*;

   nsr_step_type          step_ff, step_in;
   nsr_uword_type         uword;
   nsr_div_ctrl_type      div_ctrl;
   logic                  cond_true;

   logic [TOL_WIDTH-1:0]     tolerance_ff, tolerance_in;
   logic [RADICAND_BITS-1:0] x_ff, x_in;
   logic [EST_BITS-1:0]      k_ff, k_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ROOT_WIDTH-1:0]    root_ff, root_in;

   logic                     div_done;
   logic [QUO_WIDTH-1:0]     quotient;
   logic [QUO_WIDTH-1:0]     k_wide;
   logic [QUO_WIDTH-1:0]     gap;
   logic                     stop;
   logic [EST_BITS:0]        k_sum;
   logic                     out_free;
   logic                     accept;
   logic                     emit;

   assign uword    = microcode(step_ff);
   assign k_wide   = QUO_WIDTH'(k_ff);
   assign gap      = k_wide - quotient;
   assign stop     = (k_wide <= quotient) || (gap <= QUO_WIDTH'(tolerance_ff));
   assign k_sum    = {1'b0, quotient[EST_BITS-1:0]} + {1'b0, k_ff};
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      case (uword.cond)
         COND_ALWAYS:    cond_true = 1'b1;
         COND_REQ_VALID: cond_true = req.valid;
         COND_DIV_DONE:  cond_true = div_done;
         COND_STOP:      cond_true = stop;
         COND_OUT_FREE:  cond_true = out_free;
         default:        cond_true = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      step_in = cond_true ? uword.target_true : uword.target_false;
   end

   // control outputs
   always_comb begin
      req.ready     = uword.accept;
      accept        = uword.accept & cond_true;
      emit          = uword.emit & cond_true;
      div_ctrl.init = uword.div_init;
      div_ctrl.step = uword.div_step;
   end

   always_comb begin
      tolerance_in = csr_write_enable ? csr_write_data : tolerance_ff;
      x_in         = x_ff;
      k_in         = k_ff;
      if (accept) begin
         x_in = RADICAND_BITS'(req.radicand);
         k_in = (EST_BITS'(x_in) + EST_BITS'(1)) << (FRACTION_BITS - 1);
      end else if (uword.update) begin
         k_in = k_sum[EST_BITS:1];
      end
      root_in      = root_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (emit) begin
         root_in      = (k_wide > ROOT_MAX) ? '1 : k_wide[ROOT_WIDTH-1:0];
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      k_ff    <= k_in;
      root_ff <= root_in;
      if (reset) begin
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         tolerance_ff <= TOL_RESET;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         tolerance_ff <= tolerance_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.root  = root_ff;

   nsr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_ctrl (div_ctrl),
      .x        (x_ff),
      .den      (k_ff),
      .done     (div_done),
      .quotient (quotient)
   );

endmodule
